[rtl/fpalu_pkg.sv]
// ----------------------------------------------------------------------------
// fpalu_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Operation codes, widths and the item records passed between the parts.
// ----------------------------------------------------------------------------
package fpalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int NUM_W     = DATA_W + FRAC_BITS;  // shifted dividend width
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = 2;

    localparam logic [KIND_W-1:0] OP_ADD = 3'd0;
    localparam logic [KIND_W-1:0] OP_SUB = 3'd1;
    localparam logic [KIND_W-1:0] OP_MUL = 3'd2;
    localparam logic [KIND_W-1:0] OP_DIV = 3'd3;
    localparam logic [KIND_W-1:0] OP_MIN = 3'd4;
    localparam logic [KIND_W-1:0] OP_MAX = 3'd5;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
        logic                     a_greater;
        logic                     a_less;
        logic                     equal;
        logic                     divide_by_zero;
    } cls_item_t;

    // Finished result item.
    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     a_greater;
        logic                     a_less;
        logic                     equal;
        logic                     divide_by_zero;
    } res_item_t;

endpackage

[rtl/fixed_point_q24_8_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point arithmetic unit
// Add, subtract, multiply, divide, minimum and maximum with compare flags.
// ----------------------------------------------------------------------------
// The block looks like a queue on both sides. An item is pushed with push
// while full is low; it carries kind, operand_a and operand_b. Each item
// yields exactly one result item, shown on result and the flag ports while
// empty is low, and taken with pop.
// The front part registers and classifies each item (compare flags and
// divide by zero). A four-entry queue decouples it from the back part, a
// 42-stage pipeline: the entry stage does add, subtract, min, max and the
// multiply, then 40 restoring-divide stages, one quotient bit each, then a
// result stage that also serves as the output register.
// The result passes the front register, the queue and the back stages in
// turn; all operations take the same path so items leave in order.
// Throughput is one item per cycle while pop keeps up, since every stage,
// the divide steps included, takes a new item each cycle it advances.
// When pop stays low the back pipeline holds, the queue fills and then
// full rises. Reset clears all valid state; the block comes up empty.
// Unused kinds give result 0 with the compare flags still set.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [fpalu_pkg::KIND_W-1:0]        kind,
    input  logic signed [fpalu_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpalu_pkg::DATA_W-1:0] operand_b,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [fpalu_pkg::DATA_W-1:0] result,
    output logic                                a_greater,
    output logic                                a_less,
    output logic                                equal,
    output logic                                divide_by_zero
);

    logic                 front_ready;
    logic                 front_valid;
    fpalu_pkg::cls_item_t front_item;
    logic                 q_ready;
    logic                 q_valid;
    fpalu_pkg::cls_item_t q_item;
    logic                 back_ready;
    logic                 back_valid;
    fpalu_pkg::res_item_t back_item;

    assign full = !front_ready;

    fpalu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_ready (q_ready),
        .in_ready  (front_ready),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    fpalu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_ready (back_ready)
    );

    fpalu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_ready  (back_ready),
        .out_valid (back_valid),
        .out_item  (back_item),
        .out_ready (pop)
    );

    assign empty          = !back_valid;
    assign result         = back_item.result;
    assign a_greater      = back_item.a_greater;
    assign a_less         = back_item.a_less;
    assign equal          = back_item.equal;
    assign divide_by_zero = back_item.divide_by_zero;

endmodule

[rtl/fpalu_front.sv]
// ----------------------------------------------------------------------------
// fpalu_front: input register and classification
// Registers each accepted item, computes compare flags and divide-by-zero.
// ----------------------------------------------------------------------------
module fpalu_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [fpalu_pkg::KIND_W-1:0]          kind,
    input  logic signed [fpalu_pkg::DATA_W-1:0]   operand_a,
    input  logic signed [fpalu_pkg::DATA_W-1:0]   operand_b,
    input  logic                                  out_ready,
    output logic                                  in_ready,
    output logic                                  out_valid,
    output fpalu_pkg::cls_item_t                  out_item
);

    logic                 valid_reg;
    fpalu_pkg::cls_item_t item_reg;
    fpalu_pkg::cls_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.kind           = kind;
        item_next.operand_a      = operand_a;
        item_next.operand_b      = operand_b;
        item_next.a_greater      = operand_a > operand_b;
        item_next.a_less         = operand_a < operand_b;
        item_next.equal          = operand_a == operand_b;
        item_next.divide_by_zero = (kind == fpalu_pkg::OP_DIV) && (operand_b == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[rtl/fpalu_queue.sv]
// ----------------------------------------------------------------------------
// fpalu_queue: short queue between front and back parts
// Four-entry queue of classified items, ready while not full.
// ----------------------------------------------------------------------------
module fpalu_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  fpalu_pkg::cls_item_t in_item,
    output logic                 in_ready,
    output logic                 out_valid,
    output fpalu_pkg::cls_item_t out_item,
    input  logic                 out_ready
);

    fpalu_pkg::cls_item_t          mem_reg [fpalu_pkg::QUEUE_DEPTH];
    logic [fpalu_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [fpalu_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [fpalu_pkg::QPTR_W:0]    count_reg;
    logic                          do_wr;
    logic                          do_rd;

    assign in_ready  = count_reg != (fpalu_pkg::QPTR_W+1)'(fpalu_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/fpalu_back.sv]
// ----------------------------------------------------------------------------
// fpalu_back: execution pipeline
// Stage one does add, subtract, min, max and the multiply; a pipelined
// radix-2 divider produces one quotient bit per stage. Items stay in order.
// ----------------------------------------------------------------------------
module fpalu_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  fpalu_pkg::cls_item_t in_item,
    output logic                 in_ready,
    output logic                 out_valid,
    output fpalu_pkg::res_item_t out_item,
    input  logic                 out_ready
);

    localparam int NW    = fpalu_pkg::NUM_W;
    localparam int DW    = fpalu_pkg::DATA_W;
    localparam int STAGES = NW + 2;   // entry stage, NW divide steps, result stage

    // Per-stage pipeline record.
    typedef struct packed {
        logic [fpalu_pkg::KIND_W-1:0] kind;
        logic [DW-1:0]                early_res;  // non-divide result
        logic [NW-1:0]                quo;        // dividend bits shift into quotient
        logic [DW:0]                  rem;        // partial remainder
        logic [DW-1:0]                divisor;    // magnitude of operand_b
        logic                         neg;        // quotient sign
        logic                         a_greater;
        logic                         a_less;
        logic                         equal;
        logic                         divide_by_zero;
    } stage_t;

    logic   vld_reg [STAGES];
    stage_t stg_reg [STAGES];
    stage_t stg_next [STAGES];
    logic   advance;

    // The whole pipeline moves together; the output stage is the last entry.
    assign advance   = !vld_reg[STAGES-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[STAGES-1];

    logic signed [2*DW-1:0] prod;
    logic [DW-1:0]          mag_a;
    logic [DW-1:0]          mag_b;
    logic [DW+1:0]          trial [NW];
    logic [DW:0]            shifted [NW];
    logic [NW-1:0]          q_signed;

    always_comb
    begin
        // Entry stage: simple operations and divider setup.
        prod  = 64'(in_item.operand_a) * 64'(in_item.operand_b);
        mag_a = in_item.operand_a[DW-1] ? DW'(-in_item.operand_a) : in_item.operand_a;
        mag_b = in_item.operand_b[DW-1] ? DW'(-in_item.operand_b) : in_item.operand_b;
        stg_next[0] = '0;
        stg_next[0].kind           = in_item.kind;
        stg_next[0].a_greater      = in_item.a_greater;
        stg_next[0].a_less         = in_item.a_less;
        stg_next[0].equal          = in_item.equal;
        stg_next[0].divide_by_zero = in_item.divide_by_zero;
        stg_next[0].quo            = {mag_a, {fpalu_pkg::FRAC_BITS{1'b0}}};
        stg_next[0].divisor        = mag_b;
        stg_next[0].neg            = in_item.operand_a[DW-1] ^ in_item.operand_b[DW-1];
        case (in_item.kind)
            fpalu_pkg::OP_ADD: stg_next[0].early_res = in_item.operand_a + in_item.operand_b;
            fpalu_pkg::OP_SUB: stg_next[0].early_res = in_item.operand_a - in_item.operand_b;
            fpalu_pkg::OP_MUL: stg_next[0].early_res = prod[fpalu_pkg::FRAC_BITS +: DW];
            fpalu_pkg::OP_MIN: stg_next[0].early_res =
                in_item.a_greater ? in_item.operand_b : in_item.operand_a;
            fpalu_pkg::OP_MAX: stg_next[0].early_res =
                in_item.a_greater ? in_item.operand_a : in_item.operand_b;
            default:           stg_next[0].early_res = '0;
        endcase

        // Divide steps: restoring division, one quotient bit per stage.
        for (int s = 1; s <= NW; s++)
        begin
            stg_next[s] = stg_reg[s-1];
            shifted[s-1] = {stg_reg[s-1].rem[DW-1:0], stg_reg[s-1].quo[NW-1]};
            trial[s-1]   = {1'b0, shifted[s-1]} - {2'b00, stg_reg[s-1].divisor};
            stg_next[s].quo = {stg_reg[s-1].quo[NW-2:0], !trial[s-1][DW+1]};
            stg_next[s].rem = trial[s-1][DW+1] ? shifted[s-1] : trial[s-1][DW:0];
        end

        // Final stage: pick the result and apply the quotient sign.
        stg_next[STAGES-1] = stg_reg[STAGES-2];
        q_signed = stg_reg[STAGES-2].neg ? NW'(-stg_reg[STAGES-2].quo)
                                         : stg_reg[STAGES-2].quo;
        if (stg_reg[STAGES-2].kind == fpalu_pkg::OP_DIV)
        begin
            stg_next[STAGES-1].early_res =
                stg_reg[STAGES-2].divide_by_zero ? '0 : q_signed[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign out_item.result         = stg_reg[STAGES-1].early_res;
    assign out_item.a_greater      = stg_reg[STAGES-1].a_greater;
    assign out_item.a_less         = stg_reg[STAGES-1].a_less;
    assign out_item.equal          = stg_reg[STAGES-1].equal;
    assign out_item.divide_by_zero = stg_reg[STAGES-1].divide_by_zero;

endmodule

[verif/fixed_point_q24_8_alu_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb: self-checking bench of the Q24.8 fixed-point ALU
// Directed corner operands for every operation, then random items under three
// idling patterns; each result is checked field by field against a predictor.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_tb;

    // Operation codes that the block leaves unused.
    localparam logic [fpalu_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [fpalu_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    // One operation as pushed into the block.
    typedef struct {
        logic [fpalu_pkg::KIND_W-1:0]        kind;
        logic signed [fpalu_pkg::DATA_W-1:0] operand_a;
        logic signed [fpalu_pkg::DATA_W-1:0] operand_b;
    } alu_op_t;

    // One result as the block should present it.
    typedef struct {
        logic signed [fpalu_pkg::DATA_W-1:0] result;
        logic                                a_greater;
        logic                                a_less;
        logic                                equal;
        logic                                divide_by_zero;
    } alu_res_t;

    logic                                clk;
    logic                                rst_n;
    logic                                push;
    logic                                full;
    logic [fpalu_pkg::KIND_W-1:0]        kind;
    logic signed [fpalu_pkg::DATA_W-1:0] operand_a;
    logic signed [fpalu_pkg::DATA_W-1:0] operand_b;
    logic                                empty;
    logic                                pop;
    logic signed [fpalu_pkg::DATA_W-1:0] result;
    logic                                a_greater;
    logic                                a_less;
    logic                                equal;
    logic                                divide_by_zero;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       push_idle_pct;
    int       pop_idle_pct;
    int       error_count;
    bit       ops_done;

    fixed_point_q24_8_alu i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .a_greater      (a_greater),
        .a_less         (a_less),
        .equal          (equal),
        .divide_by_zero (divide_by_zero)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Predicts the result of one operation. Multiply takes the full 64-bit
    // product and shifts it arithmetically, which floors. Divide shifts the
    // dividend up and relies on SystemVerilog signed division truncating
    // toward zero. Everything wraps to the low 32 bits.
    function automatic alu_res_t compute_alu(alu_op_t op);
        alu_res_t         r;
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        logic signed [63:0] wide_r;
        wide_a = op.operand_a;
        wide_b = op.operand_b;
        wide_r = '0;
        r.divide_by_zero = 1'b0;
        case (op.kind)
            fpalu_pkg::OP_ADD: wide_r = wide_a + wide_b;
            fpalu_pkg::OP_SUB: wide_r = wide_a - wide_b;
            fpalu_pkg::OP_MUL: wide_r = (wide_a * wide_b) >>> fpalu_pkg::FRAC_BITS;
            fpalu_pkg::OP_DIV:
            begin
                if (wide_b == 0)
                    r.divide_by_zero = 1'b1;
                else
                    wide_r = (wide_a <<< fpalu_pkg::FRAC_BITS) / wide_b;
            end
            fpalu_pkg::OP_MIN: wide_r = (wide_a > wide_b) ? wide_b : wide_a;
            fpalu_pkg::OP_MAX: wide_r = (wide_a > wide_b) ? wide_a : wide_b;
            default: wide_r = '0;   // unused codes give zero
        endcase
        r.result    = wide_r[fpalu_pkg::DATA_W-1:0];
        r.a_greater = op.operand_a > op.operand_b;
        r.a_less    = op.operand_a < op.operand_b;
        r.equal     = op.operand_a == op.operand_b;
        return r;
    endfunction

    // Random operand: fully random half the time, else small values or edges,
    // so that equal operands, zero divisors and sign mixes show up often.
    function automatic logic signed [fpalu_pkg::DATA_W-1:0] random_operand();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 1536)) - 768;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [fpalu_pkg::KIND_W-1:0] k,
                            logic signed [fpalu_pkg::DATA_W-1:0] a,
                            logic signed [fpalu_pkg::DATA_W-1:0] b);
        alu_op_t op;
        op.kind      = k;
        op.operand_a = a;
        op.operand_b = b;
        pending_ops.push_back(op);
    endtask

    // Driver: presents the head of the pending queue at the falling edge.
    // The monitor removes the head at the edge that accepts it, so an item
    // that was refused is offered again.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            pop       <= 1'b0;
            kind      <= fpalu_pkg::OP_ADD;
            operand_a <= '0;
            operand_b <= '0;
        end
        else
        begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= push_idle_pct)
            begin
                push      <= 1'b1;
                kind      <= pending_ops[0].kind;
                operand_a <= pending_ops[0].operand_a;
                operand_b <= pending_ops[0].operand_b;
            end
            else
            begin
                push <= 1'b0;
            end
            pop <= ($urandom_range(0, 99) >= pop_idle_pct);
        end
    end

    // Monitor: the input side predicts on each accepted item, the output side
    // compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        alu_res_t want;
        if (rst_n)
        begin
            if (push && !full)
                expected_results.push_back(compute_alu(pending_ops.pop_front()));
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: result=%0d", result);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want.result)
                    begin
                        $error("result: expected %0d, got %0d", want.result, result);
                        error_count++;
                    end
                    if (a_greater !== want.a_greater)
                    begin
                        $error("a_greater: expected %0b, got %0b", want.a_greater,
                               a_greater);
                        error_count++;
                    end
                    if (a_less !== want.a_less)
                    begin
                        $error("a_less: expected %0b, got %0b", want.a_less, a_less);
                        error_count++;
                    end
                    if (equal !== want.equal)
                    begin
                        $error("equal: expected %0b, got %0b", want.equal, equal);
                        error_count++;
                    end
                    if (divide_by_zero !== want.divide_by_zero)
                    begin
                        $error("divide_by_zero: expected %0b, got %0b",
                               want.divide_by_zero, divide_by_zero);
                        error_count++;
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed corners, then three random phases with
    // different idling, then drain and report.
    initial
    begin
        int phase;
        int n;
        logic [fpalu_pkg::KIND_W-1:0]        rnd_kind;
        logic signed [fpalu_pkg::DATA_W-1:0] eq_operand;
        rst_n         = 1'b0;
        error_count   = 0;
        ops_done      = 1'b0;
        push_idle_pct = 29;
        pop_idle_pct  = 50;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: each operation on extreme operands, wrap-around on
        // add, subtract and multiply, divide by zero, divide overflow, the
        // floor of a negative product, truncation of a negative quotient,
        // minimum and maximum on equal operands, and both unused codes.
        queue_op(fpalu_pkg::OP_ADD, 32'sh7fffffff, 32'sh00000001);
        queue_op(fpalu_pkg::OP_ADD, 32'sh80000000, 32'sh80000000);
        queue_op(fpalu_pkg::OP_SUB, 32'sh80000000, 32'sh00000001);
        queue_op(fpalu_pkg::OP_SUB, 32'sh7fffffff, 32'sh80000000);
        queue_op(fpalu_pkg::OP_MUL, 32'sh7fffffff, 32'sh7fffffff);
        queue_op(fpalu_pkg::OP_MUL, 32'sh80000000, 32'sh80000000);
        queue_op(fpalu_pkg::OP_MUL, -32'sd1, 32'sd1);
        queue_op(fpalu_pkg::OP_MUL, 32'sd384, -32'sd384);
        queue_op(fpalu_pkg::OP_DIV, 32'sd256, 32'sd0);
        queue_op(fpalu_pkg::OP_DIV, 32'sd0, 32'sd0);
        queue_op(fpalu_pkg::OP_DIV, 32'sh80000000, -32'sd1);
        queue_op(fpalu_pkg::OP_DIV, 32'sh7fffffff, 32'sd1);
        queue_op(fpalu_pkg::OP_DIV, -32'sd256, 32'sd768);
        queue_op(fpalu_pkg::OP_DIV, 32'sh80000000, 32'sh7fffffff);
        queue_op(fpalu_pkg::OP_MIN, 32'sd5, 32'sd5);
        queue_op(fpalu_pkg::OP_MIN, 32'sh80000000, 32'sh7fffffff);
        queue_op(fpalu_pkg::OP_MAX, -32'sd7, -32'sd7);
        queue_op(fpalu_pkg::OP_MAX, 32'sh80000000, 32'sh7fffffff);
        queue_op(KIND_UNUSED_LO, 32'sd10, 32'sd3);
        queue_op(KIND_UNUSED_HI, -32'sd3, 32'sd10);
        queue_op(KIND_UNUSED_HI, 32'sh55555555, 32'shaaaaaaaa);

        for (phase = 0; phase < 3; phase++)
        begin
            push_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 50 : 0;
            pop_idle_pct  = (phase == 0) ? 50 : (phase == 1) ? 29 : 0;
            for (n = 0; n < 250; n++)
            begin
                // Unused codes get a small share; the six operations the rest.
                if ($urandom_range(0, 19) == 0)
                    rnd_kind = (fpalu_pkg::KIND_W)'($urandom_range(KIND_UNUSED_LO,
                                                                   KIND_UNUSED_HI));
                else
                    rnd_kind = (fpalu_pkg::KIND_W)'($urandom_range(fpalu_pkg::OP_ADD,
                                                                   fpalu_pkg::OP_MAX));
                queue_op(rnd_kind, random_operand(), random_operand());
                if ($urandom_range(0, 7) == 0)
                begin
                    eq_operand = random_operand();
                    queue_op((fpalu_pkg::KIND_W)'($urandom_range(0, 7)), eq_operand,
                             eq_operand);
                end
            end
            while (pending_ops.size() > 0)
                @(posedge clk);
        end

        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        ops_done = 1'b1;
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 850 items.
    initial
    begin
        #2000000;
        if (!ops_done)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

[files.f]
rtl/fpalu_pkg.sv
rtl/fpalu_front.sv
rtl/fpalu_queue.sv
rtl/fpalu_back.sv
rtl/fixed_point_q24_8_alu.sv
verif/fixed_point_q24_8_alu_tb.sv
